// ===== sv/iet_pkg.sv =====
`timescale 1ns / 1ps

package iet_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned KindWidth  = 3;
  localparam int unsigned DigitWidth = 4;

  localparam logic [CharWidth-1:0] ChPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] ChMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] ChStar   = 8'h2A;
  localparam logic [CharWidth-1:0] ChSlash  = 8'h2F;
  localparam logic [CharWidth-1:0] ChPct    = 8'h25;
  localparam logic [CharWidth-1:0] ChLParen = 8'h28;
  localparam logic [CharWidth-1:0] ChRParen = 8'h29;
  localparam logic [CharWidth-1:0] ChSpace  = 8'h20;
  localparam logic [CharWidth-1:0] ChNul    = 8'h00;
  localparam logic [CharWidth-1:0] ChZero   = 8'h30;
  localparam logic [CharWidth-1:0] ChNine   = 8'h39;

  typedef enum logic [2:0] {
    ClsSpace = 3'd0,
    ClsDigit = 3'd1,
    ClsOper  = 3'd2,
    ClsStop  = 3'd3,
    ClsError = 3'd4,
    ClsBrack = 3'd5
  } char_class_e;

  typedef enum logic [KindWidth-1:0] {
    TokOperand  = 3'd0,
    TokOperator = 3'd1,
    TokEnd      = 3'd2,
    TokError    = 3'd3,
    TokBracket  = 3'd4
  } token_kind_e;

  // One emitted token as held in the output stages
  typedef struct packed {
    token_kind_e           kind;
    logic [ValueWidth-1:0] value;
    logic [CharWidth-1:0]  opch;
  } token_t;

  function automatic char_class_e classify(input logic [CharWidth-1:0] c);
    char_class_e cls;
    cls = ClsError;
    if (c >= ChZero && c <= ChNine) begin
      cls = ClsDigit;
    end else begin
      case (c)
        ChPlus, ChMinus, ChStar, ChSlash, ChPct: cls = ClsOper;
        ChNul, ChRParen:                         cls = ClsStop;
        ChSpace:                                 cls = ClsSpace;
        ChLParen:                                cls = ClsBrack;
        default:                                 cls = ClsError;
      endcase
    end
    return cls;
  endfunction

endpackage

// ===== sv/infix_expression_tokenizer.sv =====
`timescale 1ns / 1ps
// Accepting the character that completes a token registers it in an output entry.
// Throughput: one character per cycle while the skid entry is empty; the class decode,
// the multiply-by-ten (two shifts and an add) and the token select all sit in one
// register-to-register stage. A two-entry output (result register plus skid register)
// keeps the input open while one token waits. Reset (rst_ni low, asynchronous) returns
// the scanner to the space class with a zero accumulator and empties both output entries.
module infix_expression_tokenizer
  import iet_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CharWidth-1:0]  char_code_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KindWidth-1:0]  token_kind_o,
  output logic [ValueWidth-1:0] operand_value_o,
  output logic [CharWidth-1:0]  operator_char_o
);

  // Scanner state
  char_class_e           prev_cls_q, prev_cls_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [CharWidth-1:0]  prev_ch_q, prev_ch_d;

  // Output entries: result register and skid register
  logic   out_valid_q, skid_valid_q;
  token_t out_q, skid_q;

  logic                  in_fire;
  logic                  out_free;
  char_class_e           cur_cls;
  char_class_e           eff_cls;
  logic [CharWidth-1:0]  eff_ch;
  logic [ValueWidth-1:0] acc_x10;
  logic [DigitWidth-1:0] digit;
  logic                  emit;
  token_t                tok;

  // Take a new transaction whenever the skid entry is empty
  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Decode the incoming character and the scanner state it meets
  always_comb begin
    cur_cls = classify(char_code_i);
    // Restart clears the state before this character is looked at
    eff_cls = restart_i ? ClsSpace : prev_cls_q;
    eff_ch  = restart_i ? ChNul : prev_ch_q;
    digit   = DigitWidth'(char_code_i - ChZero);
    acc_x10 = (acc_q << 3) + (acc_q << 1);
  end

  // Choose the token owed by the previous character
  always_comb begin
    emit      = 1'b0;
    tok.kind  = TokOperand;
    tok.value = '0;
    tok.opch  = '0;
    case (eff_cls)
      ClsDigit: begin
        if (cur_cls != ClsDigit) begin
          emit      = 1'b1;
          tok.kind  = TokOperand;
          tok.value = acc_q;
        end
      end
      ClsOper: begin
        emit     = 1'b1;
        tok.kind = TokOperator;
        tok.opch = eff_ch;
      end
      ClsStop: begin
        emit     = 1'b1;
        tok.kind = TokEnd;
      end
      ClsError: begin
        emit     = 1'b1;
        tok.kind = TokError;
      end
      ClsBrack: begin
        emit     = 1'b1;
        tok.kind = TokBracket;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Advance the scanner state; a digit run extends the accumulator, wrapping at 32 bits
  always_comb begin
    prev_cls_d = prev_cls_q;
    acc_d      = acc_q;
    prev_ch_d  = prev_ch_q;
    if (in_fire) begin
      prev_cls_d = cur_cls;
      prev_ch_d  = char_code_i;
      if (restart_i) begin
        acc_d = '0;
      end
      if (cur_cls == ClsDigit) begin
        if (eff_cls == ClsDigit) begin
          acc_d = acc_x10 + ValueWidth'(digit);
        end else begin
          acc_d = ValueWidth'(digit);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cls_q <= ClsSpace;
      acc_q      <= '0;
      prev_ch_q  <= '0;
    end else begin
      prev_cls_q <= prev_cls_d;
      acc_q      <= acc_d;
      prev_ch_q  <= prev_ch_d;
    end
  end

  // Output control: refill the result register from the skid entry first,
  // otherwise from a fresh token; park a fresh token in the skid entry when
  // the result register is still held by a stalled consumer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire && emit) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (in_fire && emit) begin
      if (out_free) begin
        out_q <= tok;
      end else begin
        skid_q <= tok;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign token_kind_o    = out_q.kind;
  assign operand_value_o = out_q.value;
  assign operator_char_o = out_q.opch;

endmodule
